[sv/pngx_pkg.sv]
// ----------------------------------------------------------------------------
// pngx_pkg: shared types and constants for the PNG pixel expander
// Mode and color type codes, register indexes, palette sizing and the
// format check used by the expander datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pngx_pkg;

    // Palette sizing
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
    localparam int PAL_CNT_W       = $clog2(PALETTE_ENTRIES + 1);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COLOR_W  = 24;
    localparam int ALPHA_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Full channel values and the wide depth
    localparam logic [SAMPLE_W-1:0] FULL16     = 16'hffff;
    localparam logic [SAMPLE_W-1:0] FULL8      = 16'h00ff;
    localparam logic [4:0]          WIDE_DEPTH = 5'd16;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_COLOR = 2'd1,
        MODE_ALPHA = 2'd2,
        MODE_CLEAR = 2'd3
    } pngx_mode_t;

    // PNG color type codes
    localparam logic [2:0] CT_GRAY       = 3'd0;
    localparam logic [2:0] CT_RGB        = 3'd2;
    localparam logic [2:0] CT_PALETTE    = 3'd3;
    localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
    localparam logic [2:0] CT_RGBA       = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_GRAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_RED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE   = 3'd6;

    // Palette lookup result handed to the expander stage
    typedef struct packed {
        logic               color_ok;   // entry written since reset
        logic               alpha_hit;  // index below alpha count
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
    } pngx_lookup_t;

    // Legal color type / bit depth pairs
    function automatic logic fmt_valid(input logic [2:0] ct, input logic [4:0] depth);
        logic ok;
        ok = 1'b0;
        case (ct)
            CT_GRAY:       ok = depth inside {5'd1, 5'd2, 5'd4, 5'd8, 5'd16};
            CT_PALETTE:    ok = depth inside {5'd1, 5'd2, 5'd4, 5'd8};
            CT_RGB,
            CT_GRAY_ALPHA,
            CT_RGBA:       ok = depth inside {5'd8, 5'd16};
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

[sv/pngx_ram.sv]
// ----------------------------------------------------------------------------
// pngx_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pngx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/pngx_palette.sv]
// ----------------------------------------------------------------------------
// pngx_palette: palette color and alpha storage
// Holds the color RAM with per-entry written flags, the append-only alpha
// RAM and its fill count. Writes happen at the input transfer; a pixel
// transfer starts a lookup whose result is valid in the cycle after it and
// holds until the next pixel transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pngx_palette (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic [1:0]                          mode,
    input  wire logic [7:0]                          entry_index,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample0,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample1,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample2,
    output pngx_pkg::pngx_lookup_t                   lookup
);

    import pngx_pkg::*;

    logic [PALETTE_ENTRIES-1:0] written_reg;
    logic [PALETTE_ENTRIES-1:0] written_next;
    logic [PAL_CNT_W-1:0]       count_reg;
    logic [PAL_CNT_W-1:0]       count_next;
    logic                       color_ok_reg;
    logic                       alpha_hit_reg;

    logic                       pix_rd;
    logic                       color_we;
    logic                       alpha_we;
    logic                       idx_in_range;
    logic                       pix_in_range;
    logic [PAL_IDX_W-1:0]       pix_addr;

    // Decode the transfer
    assign idx_in_range = {1'b0, entry_index} < 9'(PALETTE_ENTRIES);
    assign pix_in_range = {1'b0, sample0} < 17'(PALETTE_ENTRIES);
    assign pix_addr     = sample0[PAL_IDX_W-1:0];
    assign pix_rd       = accept && (mode == MODE_PIXEL);
    assign color_we     = accept && (mode == MODE_COLOR) && idx_in_range;
    assign alpha_we     = accept && (mode == MODE_ALPHA)
                          && (count_reg < PAL_CNT_W'(PALETTE_ENTRIES));

    // Written flags and alpha fill count
    always_comb
    begin
        written_next = written_reg;
        count_next   = count_reg;
        if (color_we)
        begin
            written_next[entry_index[PAL_IDX_W-1:0]] = 1'b1;
        end
        if (alpha_we)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (accept && (mode == MODE_CLEAR))
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            written_reg <= written_next;
            count_reg   <= count_next;
        end
    end

    // Lookup flags, aligned with the RAM read data
    always_ff @(posedge clk)
    begin
        if (pix_rd)
        begin
            color_ok_reg  <= pix_in_range && written_reg[pix_addr];
            alpha_hit_reg <= pix_in_range && (sample0 < SAMPLE_W'(count_reg));
        end
    end

    pngx_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (entry_index[PAL_IDX_W-1:0]),
        .wdata ({sample0[7:0], sample1[7:0], sample2[7:0]}),
        .re    (pix_rd),
        .raddr (pix_addr),
        .rdata (lookup.color)
    );

    pngx_ram #(
        .WIDTH (ALPHA_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_alpha_ram (
        .clk   (clk),
        .we    (alpha_we),
        .waddr (count_reg[PAL_IDX_W-1:0]),
        .wdata (sample0[ALPHA_W-1:0]),
        .re    (pix_rd),
        .raddr (pix_addr),
        .rdata (lookup.alpha)
    );

    assign lookup.color_ok  = color_ok_reg;
    assign lookup.alpha_hit = alpha_hit_reg;

endmodule

`default_nettype wire

[sv/png_pixel_to_rgba_expander.sv]
// ----------------------------------------------------------------------------
// png_pixel_to_rgba_expander: PNG pixel to RGBA expansion
// Pipeline: a pixel transfer is held in the lookup stage register, then in
// the output register, where its result waits until out_ready takes it.
// Throughput: one item per cycle while the output is not held back.
// Palette writes, alpha appends and clears give no result.
// Reset: registers return to RGBA/8-bit, keys off, alpha count zero; all
// palette colors read zero until written, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module png_pixel_to_rgba_expander (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration
    input  wire logic                                cfg_write,
    input  wire logic [pngx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pngx_pkg::CFG_W-1:0]          cfg_data,
    // Input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          mode,
    input  wire logic [7:0]                          entry_index,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample0,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample1,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample2,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]       sample3,
    // Output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [pngx_pkg::SAMPLE_W-1:0]            red,
    output logic [pngx_pkg::SAMPLE_W-1:0]            green,
    output logic [pngx_pkg::SAMPLE_W-1:0]            blue,
    output logic [pngx_pkg::SAMPLE_W-1:0]            alpha,
    output logic                                     bad_format
);

    import pngx_pkg::*;

    // Configuration registers
    logic [2:0]          color_type_reg;
    logic [4:0]          bit_depth_reg;
    logic                key_enable_reg;
    logic [SAMPLE_W-1:0] key_gray_reg;
    logic [SAMPLE_W-1:0] key_red_reg;
    logic [SAMPLE_W-1:0] key_green_reg;
    logic [SAMPLE_W-1:0] key_blue_reg;

    // Lookup stage
    logic                s1_valid_reg;
    logic                s1_pixel_reg;
    logic [SAMPLE_W-1:0] s1_s0_reg;
    logic [SAMPLE_W-1:0] s1_s1_reg;
    logic [SAMPLE_W-1:0] s1_s2_reg;
    logic [SAMPLE_W-1:0] s1_s3_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] red_reg;
    logic [SAMPLE_W-1:0] green_reg;
    logic [SAMPLE_W-1:0] blue_reg;
    logic [SAMPLE_W-1:0] alpha_reg;
    logic                bad_reg;

    logic                accept;
    logic                s1_advance;
    logic                out_load;
    pngx_lookup_t        lookup;

    logic [SAMPLE_W-1:0] full;
    logic [SAMPLE_W-1:0] r_next;
    logic [SAMPLE_W-1:0] g_next;
    logic [SAMPLE_W-1:0] b_next;
    logic [SAMPLE_W-1:0] a_next;
    logic                bad_next;
    logic [COLOR_W-1:0]  pal_color;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_type_reg <= CT_RGBA;
            bit_depth_reg  <= 5'd8;
            key_enable_reg <= 1'b0;
            key_gray_reg   <= '0;
            key_red_reg    <= '0;
            key_green_reg  <= '0;
            key_blue_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLOR_TYPE: color_type_reg <= cfg_data[2:0];
                REG_BIT_DEPTH:  bit_depth_reg  <= cfg_data[4:0];
                REG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                REG_KEY_GRAY:   key_gray_reg   <= cfg_data;
                REG_KEY_RED:    key_red_reg    <= cfg_data;
                REG_KEY_GREEN:  key_green_reg  <= cfg_data;
                REG_KEY_BLUE:   key_blue_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Handshake: the lookup stage moves when the output register can take it
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;
    assign out_load   = s1_advance && s1_valid_reg && s1_pixel_reg;

    pngx_palette u_palette (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .entry_index (entry_index),
        .sample0     (sample0),
        .sample1     (sample1),
        .sample2     (sample2),
        .lookup      (lookup)
    );

    // Lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= (mode == MODE_PIXEL);
            s1_s0_reg    <= sample0;
            s1_s1_reg    <= sample1;
            s1_s2_reg    <= sample2;
            s1_s3_reg    <= sample3;
        end
    end

    // Expansion by image type
    assign full      = (bit_depth_reg == WIDE_DEPTH) ? FULL16 : FULL8;
    assign pal_color = lookup.color_ok ? lookup.color : '0;

    always_comb
    begin
        r_next   = '0;
        g_next   = '0;
        b_next   = '0;
        a_next   = '0;
        bad_next = 1'b0;
        if (!fmt_valid(color_type_reg, bit_depth_reg))
        begin
            bad_next = 1'b1;
        end
        else
        begin
            case (color_type_reg)
                CT_GRAY:
                begin
                    r_next = s1_s0_reg;
                    g_next = s1_s0_reg;
                    b_next = s1_s0_reg;
                    a_next = (key_enable_reg && (s1_s0_reg == key_gray_reg)) ? '0 : full;
                end
                CT_RGB:
                begin
                    r_next = s1_s0_reg;
                    g_next = s1_s1_reg;
                    b_next = s1_s2_reg;
                    a_next = (key_enable_reg && (s1_s0_reg == key_red_reg)
                              && (s1_s1_reg == key_green_reg)
                              && (s1_s2_reg == key_blue_reg)) ? '0 : full;
                end
                CT_PALETTE:
                begin
                    r_next = {8'd0, pal_color[23:16]};
                    g_next = {8'd0, pal_color[15:8]};
                    b_next = {8'd0, pal_color[7:0]};
                    a_next = (key_enable_reg && lookup.alpha_hit)
                             ? {8'd0, lookup.alpha} : full;
                end
                CT_GRAY_ALPHA:
                begin
                    r_next = s1_s0_reg;
                    g_next = s1_s0_reg;
                    b_next = s1_s0_reg;
                    a_next = s1_s1_reg;
                end
                default:
                begin
                    r_next = s1_s0_reg;
                    g_next = s1_s1_reg;
                    b_next = s1_s2_reg;
                    a_next = s1_s3_reg;
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg && s1_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next;
            alpha_reg <= a_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign bad_format = bad_reg;

endmodule

`default_nettype wire

[dv/pngx_expand_checker.sv]
// ----------------------------------------------------------------------------
// pngx_expand_checker: result checker for the PNG pixel expander
// Watches the register port and both channels, keeps its own copy of the
// palette, alpha table and settings, predicts the RGBA result of each pixel
// transfer and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module pngx_expand_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pngx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pngx_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [1:0]                     mode,
    input  wire logic [7:0]                     entry_index,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  sample0,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  sample1,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  sample2,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  sample3,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  red,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  green,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  blue,
    input  wire logic [pngx_pkg::SAMPLE_W-1:0]  alpha,
    input  wire logic                           bad_format,
    output int                                  mismatch_count,
    output int                                  rgba_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pngx_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] alpha;
        logic                bad;
    } rgba_t;

    // Shadow settings
    logic [2:0]          ct_q;
    logic [4:0]          depth_q;
    logic                key_on_q;
    logic [SAMPLE_W-1:0] key_gray_q;
    logic [SAMPLE_W-1:0] key_red_q;
    logic [SAMPLE_W-1:0] key_green_q;
    logic [SAMPLE_W-1:0] key_blue_q;

    // Shadow palette and alpha table
    logic [COLOR_W-1:0]   pal_rgb   [PALETTE_ENTRIES];
    logic [ALPHA_W-1:0]   pal_alpha [PALETTE_ENTRIES];
    logic [PAL_CNT_W-1:0] alpha_fill;

    // Predicted results, oldest first
    rgba_t rgba_due [$];

    // Legal color type / depth pairs
    function automatic logic format_ok(input logic [2:0] ct, input logic [4:0] depth);
        logic low_pow2;
        logic byte_or_word;
        low_pow2     = (depth == 5'd1) || (depth == 5'd2) || (depth == 5'd4) ||
                       (depth == 5'd8);
        byte_or_word = (depth == 5'd8) || (depth == WIDE_DEPTH);
        case (ct)
            CT_GRAY:                        return low_pow2 || (depth == WIDE_DEPTH);
            CT_PALETTE:                     return low_pow2;
            CT_RGB, CT_GRAY_ALPHA, CT_RGBA: return byte_or_word;
            default:                        return 1'b0;
        endcase
    endfunction

    // RGBA expansion of one pixel under the current settings
    function automatic rgba_t expand_pixel(input logic [SAMPLE_W-1:0] s0,
                                           input logic [SAMPLE_W-1:0] s1,
                                           input logic [SAMPLE_W-1:0] s2,
                                           input logic [SAMPLE_W-1:0] s3);
        rgba_t               px;
        logic [SAMPLE_W-1:0] full;
        logic [COLOR_W-1:0]  rgb;
        px   = '0;
        full = (depth_q == WIDE_DEPTH) ? FULL16 : FULL8;
        if (!format_ok(ct_q, depth_q)) begin
            px.bad = 1'b1;
            return px;
        end
        case (ct_q)
            CT_GRAY: begin
                px.red   = s0;
                px.green = s0;
                px.blue  = s0;
                px.alpha = (key_on_q && s0 == key_gray_q) ? '0 : full;
            end
            CT_RGB: begin
                px.red   = s0;
                px.green = s1;
                px.blue  = s2;
                px.alpha = (key_on_q && s0 == key_red_q && s1 == key_green_q &&
                            s2 == key_blue_q) ? '0 : full;
            end
            CT_PALETTE: begin
                // index past the palette: black, opaque
                if (s0 < PALETTE_ENTRIES) begin
                    rgb      = pal_rgb[s0[PAL_IDX_W-1:0]];
                    px.red   = {8'h00, rgb[23:16]};
                    px.green = {8'h00, rgb[15:8]};
                    px.blue  = {8'h00, rgb[7:0]};
                end
                if (key_on_q && s0 < alpha_fill && s0 < PALETTE_ENTRIES)
                    px.alpha = {8'h00, pal_alpha[s0[PAL_IDX_W-1:0]]};
                else
                    px.alpha = full;
            end
            CT_GRAY_ALPHA: begin
                px.red   = s0;
                px.green = s0;
                px.blue  = s0;
                px.alpha = s1;
            end
            default: begin
                px.red   = s0;
                px.green = s1;
                px.blue  = s2;
                px.alpha = s3;
            end
        endcase
        return px;
    endfunction

    task automatic flag_result(input string what, input rgba_t want, input rgba_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: expected r=%h g=%h b=%h a=%h bad=%b, got r=%h g=%h b=%h a=%h bad=%b",
                     $time, what, want.red, want.green, want.blue, want.alpha, want.bad,
                     got.red, got.green, got.blue, got.alpha, got.bad);
    endtask

    // Track transfers: register writes, result transfers, input transfers
    always @(posedge clk or negedge rst_n) begin : track
        rgba_t got;
        rgba_t want;
        if (!rst_n) begin
            ct_q        = CT_RGBA;
            depth_q     = 5'd8;
            key_on_q    = 1'b0;
            key_gray_q  = '0;
            key_red_q   = '0;
            key_green_q = '0;
            key_blue_q  = '0;
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                pal_rgb[i]   = '0;
                pal_alpha[i] = '0;
            end
            alpha_fill = '0;
            rgba_due.delete();
            rgba_pending = 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_COLOR_TYPE: ct_q        = cfg_data[2:0];
                    REG_BIT_DEPTH:  depth_q     = cfg_data[4:0];
                    REG_KEY_ENABLE: key_on_q    = cfg_data[0];
                    REG_KEY_GRAY:   key_gray_q  = cfg_data;
                    REG_KEY_RED:    key_red_q   = cfg_data;
                    REG_KEY_GREEN:  key_green_q = cfg_data;
                    REG_KEY_BLUE:   key_blue_q  = cfg_data;
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (out_valid && out_ready) begin
                got.red   = red;
                got.green = green;
                got.blue  = blue;
                got.alpha = alpha;
                got.bad   = bad_format;
                if (rgba_due.size() == 0) begin
                    flag_result("result with nothing expected", '0, got);
                end else begin
                    want = rgba_due.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.bad !== want.bad)
                        flag_result("result mismatch", want, got);
                end
            end

            // input transfer updates the shadow state or predicts a pixel
            if (in_valid && in_ready) begin
                case (pngx_mode_t'(mode))
                    MODE_PIXEL:
                        rgba_due.insert(rgba_due.size(),
                                        expand_pixel(sample0, sample1, sample2, sample3));
                    MODE_COLOR:
                        pal_rgb[entry_index] = {sample0[7:0], sample1[7:0], sample2[7:0]};
                    MODE_ALPHA:
                        if (alpha_fill < PALETTE_ENTRIES) begin
                            pal_alpha[alpha_fill[PAL_IDX_W-1:0]] = sample0[7:0];
                            alpha_fill = alpha_fill + 1'b1;
                        end
                    MODE_CLEAR:
                        alpha_fill = '0;
                    default: ;
                endcase
            end
            rgba_pending = rgba_due.size();
        end
    end

endmodule

[dv/tb_png_pixel_to_rgba_expander.sv]
// ----------------------------------------------------------------------------
// tb_png_pixel_to_rgba_expander: testbench for the PNG pixel expander
// Drives a directed pass over every color type, key hits and misses, palette
// edges and illegal formats, a full alpha table fill, a long output stall,
// then random phases of settings and pixels with random gaps on both sides.
// Checking is done by pngx_expand_checker beside the block.
// ----------------------------------------------------------------------------
module tb_png_pixel_to_rgba_expander;
    timeunit 1ns;
    timeprecision 1ps;
    import pngx_pkg::*;

    localparam int CLK_HIGH_NS  = 6;
    localparam int CLK_LOW_NS   = 6;
    localparam int RESET_CYCLES = 4;
    localparam int ITEM_TARGET  = 1350;
    localparam int MAX_GAP      = 5;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 3_000_000;

    // color type code with no meaning
    localparam logic [2:0] CT_UNDEFINED = 3'd7;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_COLOR_TYPE;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [1:0]            mode        = MODE_PIXEL;
    logic [7:0]            entry_index = '0;
    logic [SAMPLE_W-1:0]   sample0     = '0;
    logic [SAMPLE_W-1:0]   sample1     = '0;
    logic [SAMPLE_W-1:0]   sample2     = '0;
    logic [SAMPLE_W-1:0]   sample3     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [SAMPLE_W-1:0]   red;
    logic [SAMPLE_W-1:0]   green;
    logic [SAMPLE_W-1:0]   blue;
    logic [SAMPLE_W-1:0]   alpha;
    logic                  bad_format;
    int                    mismatch_count;
    int                    rgba_pending;

    // Shared knobs between stimulus and result sink
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int items_sent   = 0;

    // Settings currently loaded, used to aim pixels at the keys
    logic [2:0]          cur_ct        = CT_RGBA;
    logic [4:0]          cur_depth     = 5'd8;
    logic [SAMPLE_W-1:0] cur_key_gray  = '0;
    logic [SAMPLE_W-1:0] cur_key_red   = '0;
    logic [SAMPLE_W-1:0] cur_key_green = '0;
    logic [SAMPLE_W-1:0] cur_key_blue  = '0;

    png_pixel_to_rgba_expander dut (.*);

    pngx_expand_checker rgba_check (.*);

    always
    begin
        #CLK_LOW_NS clk = 1'b1;
        #CLK_HIGH_NS clk = 1'b0;
    end

    // Random 16-bit sample and random palette index
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic [7:0] rand_index();
        return 8'($urandom_range(0, 255));
    endfunction

    // Sample value: zero, all ones, raw 16 bits, or within the bit depth
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [4:0] depth);
        logic [31:0] raw;
        logic [16:0] span;
        raw  = $urandom();
        span = (17'd1 << depth) - 17'd1;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2, 3, 4: return raw[15:0];
            default: return raw[15:0] & span[15:0];
        endcase
    endfunction

    // One input transfer; valid stays high afterwards until the next call
    // or until the sender parks the channel
    task automatic push_item(input pngx_mode_t m, input logic [7:0] idx,
                             input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
                             input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        sample0     <= s0;
        sample1     <= s1;
        sample2     <= s2;
        sample3     <= s3;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Random pixel for the loaded settings
    task automatic push_pixel();
        logic [SAMPLE_W-1:0] s [4];
        int                  lane;
        int                  bit_pos;
        for (int k = 0; k < 4; k++)
            s[k] = pick_sample(cur_depth);
        if (cur_ct == CT_PALETTE) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: s[0] = SAMPLE_W'($urandom_range(0, 31));
                6, 7, 8:          s[0] = SAMPLE_W'($urandom_range(0, PALETTE_ENTRIES - 1));
                default:          s[0] = SAMPLE_W'($urandom_range(PALETTE_ENTRIES, 16'hffff));
            endcase
        end else if ($urandom_range(0, 3) == 0) begin
            // land on the transparency key, now and then one bit off
            s[0] = (cur_ct == CT_GRAY) ? cur_key_gray : cur_key_red;
            s[1] = cur_key_green;
            s[2] = cur_key_blue;
            if ($urandom_range(0, 2) == 0) begin
                lane          = $urandom_range(0, 2);
                bit_pos       = $urandom_range(0, SAMPLE_W - 1);
                s[lane][bit_pos] = ~s[lane][bit_pos];
            end
        end
        push_item(MODE_PIXEL, rand_index(), s[0], s[1], s[2], s[3]);
    endtask

    // Park the input and wait until every result is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (rgba_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Load all settings while the block is idle
    task automatic load_config(input logic [2:0] ct, input logic [4:0] depth,
                               input logic key_on, input logic [SAMPLE_W-1:0] kg,
                               input logic [SAMPLE_W-1:0] kr, input logic [SAMPLE_W-1:0] kgn,
                               input logic [SAMPLE_W-1:0] kb);
        settle();
        write_reg(REG_COLOR_TYPE, CFG_W'(ct));
        write_reg(REG_BIT_DEPTH, CFG_W'(depth));
        write_reg(REG_KEY_ENABLE, CFG_W'(key_on));
        write_reg(REG_KEY_GRAY, kg);
        write_reg(REG_KEY_RED, kr);
        write_reg(REG_KEY_GREEN, kgn);
        write_reg(REG_KEY_BLUE, kb);
        cfg_write     <= 1'b0;
        cur_ct        = ct;
        cur_depth     = depth;
        cur_key_gray  = kg;
        cur_key_red   = kr;
        cur_key_green = kgn;
        cur_key_blue  = kb;
        @(posedge clk);
    endtask

    // One random phase: settings, palette setup where it matters, pixels
    task automatic random_phase();
        logic [2:0] ct;
        logic [4:0] depth;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
                0:       ct = CT_GRAY;
                1:       ct = CT_RGB;
                2:       ct = CT_PALETTE;
                3:       ct = CT_GRAY_ALPHA;
                default: ct = CT_RGBA;
            endcase
        end else begin
            ct = 3'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 9) < 8) begin
            case (ct)
                CT_GRAY:    depth = 5'd1 << $urandom_range(0, 4);
                CT_PALETTE: depth = 5'd1 << $urandom_range(0, 3);
                default:    depth = $urandom_range(0, 1) ? 5'd8 : WIDE_DEPTH;
            endcase
        end else begin
            depth = 5'($urandom_range(0, 31));
        end
        gaps_on = ($urandom_range(0, 3) != 0);
        load_config(ct, depth, $urandom_range(0, 3) != 0, pick_sample(depth),
                    pick_sample(depth), pick_sample(depth), pick_sample(depth));

        // palette setup: optional clear, a few colors, a few alphas
        if (ct == CT_PALETTE) begin
            if ($urandom_range(0, 1))
                push_item(MODE_CLEAR, rand_index(), rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
            repeat ($urandom_range(1, 12))
                push_item(MODE_COLOR,
                          8'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 255)),
                          rand_sample(), rand_sample(), rand_sample(), rand_sample());
            repeat ($urandom_range(0, 24))
                push_item(MODE_ALPHA, rand_index(), rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
        end

        // pixels with a little noise of other item kinds
        repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 19) == 0)
                push_item(pngx_mode_t'(2'($urandom_range(0, 3))), rand_index(),
                          rand_sample(), rand_sample(), rand_sample(), rand_sample());
            else
                push_pixel();
        end
    endtask

    // Result side: random ready gaps, one long hold-off on request
    initial begin : result_sink
        int pause;
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                pause = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
                if (pause > 0) begin
                    out_ready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: RGBA, 8 bit
        push_item(MODE_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        // gray 16 bit: key hit at all ones, miss at zero
        load_config(CT_GRAY, WIDE_DEPTH, 1'b1, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'hffff, 16'h1234, 16'h5678, 16'h9abc);
        push_item(MODE_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // RGB key: exact hit, then blue one off
        load_config(CT_RGB, 5'd8, 1'b1, 16'h0000, 16'h0012, 16'h0034, 16'h0056);
        push_item(MODE_PIXEL, 8'h00, 16'h0012, 16'h0034, 16'h0056, 16'hffff);
        push_item(MODE_PIXEL, 8'h00, 16'h0012, 16'h0034, 16'h0057, 16'h0000);

        // palette: unwritten entry, edge entries, stored alphas, index past
        // the palette, clear
        load_config(CT_PALETTE, 5'd8, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'd5, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_COLOR, 8'h00, 16'hab12, 16'hcd34, 16'hef56, 16'hffff);
        push_item(MODE_COLOR, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_item(MODE_ALPHA, 8'h00, 16'h1180, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_ALPHA, 8'hff, 16'hff00, 16'hffff, 16'hffff, 16'hffff);
        push_item(MODE_PIXEL, 8'h00, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'd1, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'd255, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'd256, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_item(MODE_CLEAR, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'd0, 16'h0000, 16'h0000, 16'h0000);

        // gray+alpha 16 bit
        load_config(CT_GRAY_ALPHA, WIDE_DEPTH, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'h1234, 16'h0000, 16'hffff, 16'hffff);

        // illegal formats: undefined color type, RGBA at depth zero
        load_config(CT_UNDEFINED, 5'd8, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_item(MODE_PIXEL, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        load_config(CT_RGBA, 5'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_PIXEL, 8'h00, 16'h8001, 16'h4002, 16'h2004, 16'h1008);

        // fill the alpha table past its end at depth 1
        load_config(CT_PALETTE, 5'd1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(MODE_CLEAR, rand_index(), rand_sample(), rand_sample(), rand_sample(),
                  rand_sample());
        repeat (20)
            push_item(MODE_COLOR, rand_index(), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample());
        repeat (PALETTE_ENTRIES + 4)
            push_item(MODE_ALPHA, rand_index(), rand_sample(), rand_sample(), rand_sample(),
                      rand_sample());
        repeat (30) push_pixel();

        // long output hold-off while pixels keep coming back to back
        load_config(CT_RGBA, WIDE_DEPTH, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (40) push_pixel();

        while (items_sent < ITEM_TARGET)
            random_phase();

        settle();
        if (mismatch_count == 0 && rgba_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

endmodule

[png_pixel_to_rgba_expander.f]
sv/pngx_pkg.sv
sv/pngx_ram.sv
sv/pngx_palette.sv
sv/png_pixel_to_rgba_expander.sv
dv/pngx_expand_checker.sv
dv/tb_png_pixel_to_rgba_expander.sv
